### hdl/hbs_pkg.sv
package hbs_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_DEPTH   = 256;
	localparam int HEIGHT_BITS = 16;

	localparam int MEM_DEPTH = MAX_WIDTH * MAX_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int COORD_W   = $clog2(MAX_WIDTH);
	localparam int TEXEL_W   = 8;
	localparam int SIZE_W    = 9;
	localparam int WORLD_W   = 32;
	localparam int INV_W     = 32;
	localparam int SCALE_W   = 16;
	localparam int WH_W      = 16;
	localparam int FRAC_W    = 16;
	localparam int OUT_W     = 32;
	localparam int RAW_SHIFT = 8;

	// texel coordinate after the world mapping: full product floored to Q.16
	localparam int TC_W   = 2 * WORLD_W + 1 - FRAC_W;
	// one row blended along x, then pre-shifted by 8
	localparam int ROW_W  = HEIGHT_BITS + FRAC_W;
	localparam int ROWS_W = ROW_W - 8;
	// blend times scale, floored by 8
	localparam int RES_W  = ROWS_W + 9;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// back end step counter
	localparam int STEP_W = 3;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_DEPTH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE  = 3'd6;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_READ   = 2'd1,
		KIND_SAMPLE = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MULX,
		F_MULZ,
		F_CLAMP,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_RUN,
		B_EMIT
	} back_state_t;

	// effective settings seen by the front and back
	typedef struct packed {
		logic [SIZE_W-1:0]         width;
		logic [SIZE_W-1:0]         depth;
		logic signed [WORLD_W-1:0] origin_x;
		logic signed [WORLD_W-1:0] origin_z;
		logic [INV_W-1:0]          inv_x;
		logic [INV_W-1:0]          inv_z;
		logic [SCALE_W-1:0]        scale;
	} cfg_t;

	typedef struct packed {
		kind_t                   kind;
		logic [ADDR_W-1:0]       addr;
		logic                    oor;
		logic signed [WH_W-1:0]  wheight;
		logic [FRAC_W-1:0]       fx;
		logic [FRAC_W-1:0]       fz;
	} cmd_t;

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] vmax);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v < SIZE_W'(3))
			r = SIZE_W'(3);
		else if (v > vmax)
			r = vmax;
		return r;
	endfunction

endpackage

### hdl/hbs_front.sv
module hbs_front import hbs_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  logic                        clear_busy,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [95:0]                 s_axis_tdata,
	input  logic [1:0]                  s_axis_tuser,
	output logic                        push,
	output cmd_t                        push_data,
	input  logic                        full
);

	front_state_t state_q, state_d;

	kind_t                      kind_q;
	logic [TEXEL_W-1:0]         tx_q, tz_q;
	logic signed [WH_W-1:0]     wh_q;
	logic signed [WORLD_W:0]    dx_q, dz_q;
	logic signed [TC_W-1:0]     tcx_q, tcz_q;
	logic [COORD_W-1:0]         ix_q, iz_q;
	logic                       oor_q;

	logic                           accept;
	logic signed [WORLD_W:0]        mul_d;
	logic [INV_W-1:0]               mul_inv;
	logic signed [2*WORLD_W+1:0]    mul_p;
	logic [ADDR_W-1:0]              addr;
	logic signed [WORLD_W-1:0]      world_x, world_z;

	function automatic logic [COORD_W-1:0] clamp_cell(input logic signed [TC_W-1:0] t,
			input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] hi;
		logic [COORD_W-1:0] r;
		hi = size - SIZE_W'(2);
		if (t[TC_W-1])
			r = '0;
		else if (t[TC_W-2:FRAC_W] > (TC_W-1-FRAC_W)'(hi))
			r = hi[COORD_W-1:0];
		else
			r = t[FRAC_W+COORD_W-1:FRAC_W];
		return r;
	endfunction

	assign world_x = $signed(s_axis_tdata[63:32]);
	assign world_z = $signed(s_axis_tdata[95:64]);

	// one shared multiplier for both axes
	assign mul_d   = (state_q == F_MULX) ? dx_q : dz_q;
	assign mul_inv = (state_q == F_MULX) ? cfg.inv_x : cfg.inv_z;
	assign mul_p   = mul_d * $signed({1'b0, mul_inv});

	assign addr = ADDR_W'(iz_q) * ADDR_W'(cfg.width) + ADDR_W'(ix_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept)
					state_d = (kind_t'(s_axis_tuser) == KIND_SAMPLE) ? F_MULX : F_CLAMP;
			end
			F_MULX:  state_d = F_MULZ;
			F_MULZ:  state_d = F_CLAMP;
			F_CLAMP: state_d = F_PUSH;
			F_PUSH: begin
				if (!full)
					state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready     = (state_q == F_IDLE) && !clear_busy;
		push              = (state_q == F_PUSH);
		push_data.kind    = kind_q;
		push_data.addr    = addr;
		push_data.oor     = oor_q;
		push_data.wheight = wh_q;
		push_data.fx      = tcx_q[FRAC_W-1:0];
		push_data.fz      = tcz_q[FRAC_W-1:0];
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					kind_q <= kind_t'(s_axis_tuser);
					tx_q   <= s_axis_tdata[7:0];
					tz_q   <= s_axis_tdata[15:8];
					wh_q   <= $signed(s_axis_tdata[31:16]);
					dx_q   <= $signed({world_x[WORLD_W-1], world_x})
					        - $signed({cfg.origin_x[WORLD_W-1], cfg.origin_x});
					dz_q   <= $signed({world_z[WORLD_W-1], world_z})
					        - $signed({cfg.origin_z[WORLD_W-1], cfg.origin_z});
					tcx_q  <= '0;
					tcz_q  <= '0;
				end
			end
			F_MULX: tcx_q <= $signed(mul_p[2*WORLD_W:FRAC_W]);
			F_MULZ: tcz_q <= $signed(mul_p[2*WORLD_W:FRAC_W]);
			F_CLAMP: begin
				if (kind_q == KIND_SAMPLE) begin
					ix_q  <= clamp_cell(tcx_q, cfg.width);
					iz_q  <= clamp_cell(tcz_q, cfg.depth);
					oor_q <= 1'b0;
				end else begin
					ix_q  <= COORD_W'(tx_q);
					iz_q  <= COORD_W'(tz_q);
					oor_q <= (SIZE_W'(tx_q) >= cfg.width) || (SIZE_W'(tz_q) >= cfg.depth);
				end
			end
			default: ;
		endcase
	end

endmodule

### hdl/hbs_queue.sv
module hbs_queue import hbs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cmd_t  push_data,
	output logic  full,
	input  logic  pop,
	output cmd_t  pop_data,
	output logic  not_empty
);

	cmd_t                 entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wr_q, rd_q;
	logic [QPTR_W:0]      count_q;
	logic                 do_push, do_pop;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_q] <= push_data;
	end

endmodule

### hdl/hbs_back.sv
module hbs_back import hbs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	output logic               clear_busy,
	input  logic               q_valid,
	input  cmd_t               q_data,
	output logic               q_pop,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [OUT_W-1:0]   m_axis_tdata,
	output logic [1:0]         m_axis_tuser
);

	back_state_t state_q, state_d;
	logic [STEP_W-1:0]  step_q;
	logic [ADDR_W-1:0]  clr_q;
	cmd_t               cmd_q;
	logic               m_valid_q;

	logic [HEIGHT_BITS-1:0] mem [MEM_DEPTH];
	logic signed [HEIGHT_BITS-1:0] rd_q;

	logic signed [HEIGHT_BITS-1:0] t00_q, t10_q, t01_q;
	logic signed [ROW_W-1:0]       h0_q, h1_q;
	logic signed [ROWS_W-1:0]      hb_q;
	logic signed [RES_W-1:0]       res_q;
	logic                          oor_q;
	logic [OUT_W-1:0]              m_data_q;
	logic [1:0]                    m_user_q;

	logic                          mem_we;
	logic [ADDR_W-1:0]             mem_waddr, mem_raddr;
	logic [HEIGHT_BITS-1:0]        mem_wdata;
	logic                          run_done, out_load;

	logic signed [HEIGHT_BITS-1:0] bl_a, bl_b;
	logic signed [HEIGHT_BITS:0]   bl_diff;
	logic signed [HEIGHT_BITS+17:0] bl_sum;
	logic signed [ROWS_W-1:0]      h0s, h1s;
	logic signed [ROWS_W:0]        vd;
	logic signed [ROWS_W+17:0]     v_sum;
	logic signed [ROWS_W+16:0]     sc_p;
	logic [RES_W-OUT_W:0]          res_top;
	logic                          res_fits;
	logic [OUT_W-1:0]              res_sat;

	// x blend shared by both rows: a*65536 + (b-a)*fx
	assign bl_a    = (step_q == STEP_W'(3)) ? t00_q : t01_q;
	assign bl_b    = (step_q == STEP_W'(3)) ? t10_q : rd_q;
	assign bl_diff = (HEIGHT_BITS+1)'(bl_b) - (HEIGHT_BITS+1)'(bl_a);
	assign bl_sum  = bl_diff * $signed({1'b0, cmd_q.fx})
	               + (HEIGHT_BITS+18)'($signed({bl_a, {FRAC_W{1'b0}}}));

	// z blend on rows floored by 8
	assign h0s   = $signed(h0_q[ROW_W-1:8]);
	assign h1s   = $signed(h1_q[ROW_W-1:8]);
	assign vd    = (ROWS_W+1)'(h1s) - (ROWS_W+1)'(h0s);
	assign v_sum = vd * $signed({1'b0, cmd_q.fz})
	             + (ROWS_W+18)'($signed({h0s, {FRAC_W{1'b0}}}));

	assign sc_p = hb_q * $signed({1'b0, cfg.scale});

	assign res_top  = res_q[RES_W-1:OUT_W-1];
	assign res_fits = (&res_top) || !(|res_top);
	assign res_sat  = res_fits ? res_q[OUT_W-1:0]
	                : (res_q[RES_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
	                                  : {1'b0, {(OUT_W-1){1'b1}}});

	always_comb begin
		case (cmd_q.kind)
			KIND_READ:   run_done = (step_q == STEP_W'(1));
			KIND_SAMPLE: run_done = (step_q == STEP_W'(6));
			default:     run_done = 1'b1;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR: begin
				if (clr_q == {ADDR_W{1'b1}})
					state_d = B_IDLE;
			end
			B_IDLE: begin
				if (q_valid)
					state_d = B_RUN;
			end
			B_RUN: begin
				if (run_done)
					state_d = B_EMIT;
			end
			B_EMIT: begin
				if (!m_valid_q || m_axis_tready)
					state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		clear_busy = (state_q == B_CLEAR);
		q_pop      = (state_q == B_IDLE) && q_valid;
		out_load   = (state_q == B_EMIT) && (!m_valid_q || m_axis_tready);
		mem_we     = clear_busy || ((state_q == B_RUN) && (step_q == '0)
		             && (cmd_q.kind == KIND_WRITE) && !cmd_q.oor);
		mem_waddr  = clear_busy ? clr_q : cmd_q.addr;
		mem_wdata  = clear_busy ? '0 : HEIGHT_BITS'(cmd_q.wheight);
		case (step_q)
			STEP_W'(0): mem_raddr = cmd_q.addr;
			STEP_W'(1): mem_raddr = cmd_q.addr + ADDR_W'(1);
			STEP_W'(2): mem_raddr = cmd_q.addr + ADDR_W'(cfg.width);
			default:    mem_raddr = cmd_q.addr + ADDR_W'(cfg.width) + ADDR_W'(1);
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_q <= $signed(mem[mem_raddr]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_q     <= '0;
			step_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clear_busy)
				clr_q <= clr_q + 1'b1;
			if (q_pop)
				step_q <= '0;
			else if (state_q == B_RUN)
				step_q <= step_q + 1'b1;
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cmd_q <= q_data;
		if (state_q == B_RUN) begin
			if (step_q == '0) begin
				oor_q <= (cmd_q.kind inside {KIND_WRITE, KIND_READ}) && cmd_q.oor;
				res_q <= '0;
			end
			case (cmd_q.kind)
				KIND_READ: begin
					if (step_q == STEP_W'(1) && !cmd_q.oor)
						res_q <= RES_W'($signed({rd_q, {RAW_SHIFT{1'b0}}}));
				end
				KIND_SAMPLE: begin
					case (step_q)
						STEP_W'(1): t00_q <= rd_q;
						STEP_W'(2): t10_q <= rd_q;
						STEP_W'(3): begin
							t01_q <= rd_q;
							h0_q  <= bl_sum[ROW_W-1:0];
						end
						STEP_W'(4): h1_q  <= bl_sum[ROW_W-1:0];
						STEP_W'(5): hb_q  <= $signed(v_sum[ROWS_W+15:FRAC_W]);
						STEP_W'(6): res_q <= $signed(sc_p[ROWS_W+16:8]);
						default: ;
					endcase
				end
				default: ;
			endcase
		end
		if (out_load) begin
			m_data_q <= res_sat;
			m_user_q <= {!res_fits, oor_q};
		end
	end

endmodule

### hdl/heightmap_bilinear_sampler.sv
// Channel  Direction  Handshake              Payload
// s_axis   in         tvalid/tready          tdata: texel_x, texel_z, write_height,
//                                            world_x, world_z; tuser: kind
// m_axis   out        tvalid/tready          tdata: height_out; tuser: out_of_range,
//                                            saturated
// cfg      in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// The front takes a new item once the last is pushed (a sample first makes two
// passes through one 33x33 multiplier); a 2-deep queue feeds the back. A sample
// takes more back steps than a raw read, a raw read more than a write, set by
// the single read port of the height store and the shared blend multiplier.
// After reset a clearing pass zeroes all 65536 store entries with s_axis_tready
// low; configuration writes are taken throughout. The output register lets the
// back finish the next item while a result waits on m_axis_tready.
module heightmap_bilinear_sampler import hbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [7:0] texel_x, [15:8] texel_z, [31:16] write_height, [63:32] world_x,
	// [95:64] world_z
	input  logic [95:0]          s_axis_tdata,
	// [1:0] kind
	input  logic [1:0]           s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [31:0] height_out
	output logic [31:0]          m_axis_tdata,
	// [0] out_of_range, [1] saturated
	output logic [1:0]           m_axis_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	logic [SIZE_W-1:0]         map_width_q, map_depth_q;
	logic signed [WORLD_W-1:0] origin_x_q, origin_z_q;
	logic [INV_W-1:0]          inv_x_q, inv_z_q;
	logic [SCALE_W-1:0]        scale_q;

	cfg_t  cfg;
	cmd_t  push_data, pop_data;
	logic  push, full, pop, not_empty, clear_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q <= SIZE_W'(256);
			map_depth_q <= SIZE_W'(256);
			origin_x_q  <= '0;
			origin_z_q  <= '0;
			inv_x_q     <= INV_W'(65536);
			inv_z_q     <= INV_W'(65536);
			scale_q     <= SCALE_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAP_WIDTH:     map_width_q <= cfg_data[SIZE_W-1:0];
				REG_MAP_DEPTH:     map_depth_q <= cfg_data[SIZE_W-1:0];
				REG_ORIGIN_X:      origin_x_q  <= $signed(cfg_data);
				REG_ORIGIN_Z:      origin_z_q  <= $signed(cfg_data);
				REG_INV_SPACING_X: inv_x_q     <= cfg_data;
				REG_INV_SPACING_Z: inv_z_q     <= cfg_data;
				REG_HEIGHT_SCALE:  scale_q     <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.width    = eff_size(map_width_q, SIZE_W'(MAX_WIDTH));
		cfg.depth    = eff_size(map_depth_q, SIZE_W'(MAX_DEPTH));
		cfg.origin_x = origin_x_q;
		cfg.origin_z = origin_z_q;
		cfg.inv_x    = inv_x_q;
		cfg.inv_z    = inv_z_q;
		cfg.scale    = scale_q;
	end

	hbs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.clear_busy    (clear_busy),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push          (push),
		.push_data     (push_data),
		.full          (full)
	);

	hbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	hbs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.clear_busy    (clear_busy),
		.q_valid       (not_empty),
		.q_data        (pop_data),
		.q_pop         (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import hbs_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 200000;

	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  tx;
		logic [7:0]  tz;
		logic [15:0] wh;
		logic [31:0] wx;
		logic [31:0] wz;
	} request_t;

	typedef struct {
		logic [31:0] height;
		logic        oor;
		logic        sat;
	} terrain_reply_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [95:0]          s_axis_tdata = '0;
	logic [1:0]           s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [31:0]          m_axis_tdata;
	logic [1:0]           m_axis_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	// shadow of the block's settings and height store
	logic [8:0]         map_w_reg = 9'd256;
	logic [8:0]         map_d_reg = 9'd256;
	logic signed [31:0] org_x_reg = '0;
	logic signed [31:0] org_z_reg = '0;
	logic [31:0]        inv_x_reg = 32'h0001_0000;
	logic [31:0]        inv_z_reg = 32'h0001_0000;
	logic [15:0]        scale_reg = 16'h0100;
	logic signed [15:0] terrain [0:65535];

	request_t       request_q[$];
	terrain_reply_t reply_expect_q[$];

	logic req_taken = 1'b0;
	logic calm = 1'b0;
	int   quiet_cycles = 0;
	int   requests_queued = 0;
	int   requests_taken = 0;
	int   error_count = 0;
	int   n_writes = 0, n_reads = 0, n_samples = 0, n_unused = 0, n_oor = 0;
	int   n_layouts = 0;

	heightmap_bilinear_sampler u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int eff_span(input logic [8:0] v);
		if (v < 9'd3)
			return 3;
		if (v > 9'd256)
			return 256;
		return int'(v);
	endfunction

	// exact product floored to a 16-bit fraction
	function automatic void world_to_texel(input logic signed [31:0] world,
			input logic signed [31:0] origin, input logic [31:0] inv,
			output longint coord_int, output logic [15:0] frac);
		longint      diff;
		longint      t;
		logic [63:0] mag;
		logic [63:0] prod;
		diff = longint'(world) - longint'(origin);
		mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
		prod = mag * {32'b0, inv};
		if (diff < 0)
			t = -longint'((prod >> 16) + 64'(prod[15:0] != 16'd0));
		else
			t = longint'(prod >> 16);
		frac = t[15:0];
		coord_int = t >>> 16;
	endfunction

	function automatic void fit_height(input longint v, output logic [31:0] h,
			output logic clipped);
		clipped = 1'b1;
		if (v > longint'(32'sh7FFF_FFFF))
			h = 32'h7FFF_FFFF;
		else if (v < -longint'(64'h8000_0000))
			h = 32'h8000_0000;
		else begin
			h = v[31:0];
			clipped = 1'b0;
		end
	endfunction

	task automatic predict_terrain_reply(input logic [1:0] kind, input logic [95:0] data,
			output terrain_reply_t r);
		int          w, d, base;
		logic [7:0]  tx, tz;
		logic [15:0] fx, fz;
		longint      cx, cz, h00, h10, h01, h11, row0, row1, blend;
		tx = data[7:0];
		tz = data[15:8];
		w = eff_span(map_w_reg);
		d = eff_span(map_d_reg);
		r.height = '0;
		r.oor = 1'b0;
		r.sat = 1'b0;
		case (kind)
			KIND_WRITE: begin
				if (tx >= w || tz >= d)
					r.oor = 1'b1;
				else
					terrain[tz * w + tx] = data[31:16];
			end
			KIND_READ: begin
				if (tx >= w || tz >= d)
					r.oor = 1'b1;
				else
					fit_height(longint'(terrain[tz * w + tx]) * 256, r.height, r.sat);
			end
			KIND_SAMPLE: begin
				world_to_texel(data[63:32], org_x_reg, inv_x_reg, cx, fx);
				world_to_texel(data[95:64], org_z_reg, inv_z_reg, cz, fz);
				// clamp the cell only; the fraction stays from the raw coordinate
				if (cx < 0) cx = 0;
				if (cx > w - 2) cx = w - 2;
				if (cz < 0) cz = 0;
				if (cz > d - 2) cz = d - 2;
				base = int'(cz) * w + int'(cx);
				h00 = longint'(terrain[base]);
				h10 = longint'(terrain[base + 1]);
				h01 = longint'(terrain[base + w]);
				h11 = longint'(terrain[base + w + 1]);
				row0 = h00 * (65536 - longint'(fx)) + h10 * longint'(fx);
				row1 = h01 * (65536 - longint'(fx)) + h11 * longint'(fx);
				blend = ((row0 >>> 8) * (65536 - longint'(fz)) + (row1 >>> 8) * longint'(fz))
					>>> 16;
				fit_height((blend * longint'(scale_reg)) >>> 8, r.height, r.sat);
			end
			default: ;
		endcase
	endtask

	// input driver: hold an item until its transfer, then advance or idle
	always @(negedge clk) begin : feeder
		request_t nxt;
		if (!s_axis_tvalid || req_taken) begin
			if (request_q.size() != 0 && (calm || $urandom_range(0, 99) >= 11)) begin
				nxt = request_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= nxt.kind;
				s_axis_tdata <= {nxt.wz, nxt.wx, nxt.wh, nxt.tz, nxt.tx};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 11);
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		terrain_reply_t want;
		logic           busy;
		if (!arst_n) begin
			req_taken <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			busy = 1'b0;
			if (m_axis_tvalid && m_axis_tready) begin
				busy = 1'b1;
				if (reply_expect_q.size() == 0) begin
					$error("result with nothing expected: height_out %0d", $signed(m_axis_tdata));
					error_count++;
				end else begin
					want = reply_expect_q.pop_front();
					if (m_axis_tdata !== want.height) begin
						$error("height_out: expected %0d, actual %0d", $signed(want.height),
							$signed(m_axis_tdata));
						error_count++;
					end
					if (m_axis_tuser[0] !== want.oor) begin
						$error("out_of_range: expected %0b, actual %0b", want.oor, m_axis_tuser[0]);
						error_count++;
					end
					if (m_axis_tuser[1] !== want.sat) begin
						$error("saturated: expected %0b, actual %0b", want.sat, m_axis_tuser[1]);
						error_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				busy = 1'b1;
				case (cfg_index)
					REG_MAP_WIDTH:     map_w_reg = cfg_data[8:0];
					REG_MAP_DEPTH:     map_d_reg = cfg_data[8:0];
					REG_ORIGIN_X:      org_x_reg = cfg_data;
					REG_ORIGIN_Z:      org_z_reg = cfg_data;
					REG_INV_SPACING_X: inv_x_reg = cfg_data;
					REG_INV_SPACING_Z: inv_z_reg = cfg_data;
					REG_HEIGHT_SCALE:  scale_reg = cfg_data[15:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				busy = 1'b1;
				predict_terrain_reply(s_axis_tuser, s_axis_tdata, want);
				reply_expect_q.insert(reply_expect_q.size(), want);
				requests_taken++;
				case (s_axis_tuser)
					KIND_WRITE:  n_writes++;
					KIND_READ:   n_reads++;
					KIND_SAMPLE: n_samples++;
					default:     n_unused++;
				endcase
				if (want.oor)
					n_oor++;
			end
			req_taken <= s_axis_tvalid && s_axis_tready;
			quiet_cycles <= busy ? 0 : quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	task automatic queue_request(input logic [1:0] kind, input logic [7:0] tx, tz,
			input logic [15:0] wh, input logic [31:0] wx, wz);
		request_t r;
		r.kind = kind;
		r.tx = tx;
		r.tz = tz;
		r.wh = wh;
		r.wx = wx;
		r.wz = wz;
		request_q.insert(request_q.size(), r);
		requests_queued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// narrow registers get junk in the unused upper bits
	task automatic program_map(input logic [8:0] w, d, input logic [31:0] ox, oz, ix, iz,
			input logic [15:0] sc);
		write_reg(REG_MAP_WIDTH, ($urandom & 32'hFFFF_FE00) | 32'(w));
		write_reg(REG_MAP_DEPTH, ($urandom & 32'hFFFF_FE00) | 32'(d));
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_INV_SPACING_X, ix);
		write_reg(REG_INV_SPACING_Z, iz);
		write_reg(REG_HEIGHT_SCALE, ($urandom & 32'hFFFF_0000) | 32'(sc));
		n_layouts++;
	endtask

	// hold the sender until every result is back, then let the back end drain
	task automatic settle();
		while (requests_taken != requests_queued || reply_expect_q.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	function automatic logic [8:0] pick_size();
		case ($urandom_range(0, 5))
			0: return 9'($urandom_range(0, 2));
			1: return 9'($urandom_range(3, 12));
			2: return 9'd256;
			3: return 9'($urandom_range(257, 511));
			default: return 9'($urandom_range(3, 256));
		endcase
	endfunction

	function automatic logic [31:0] pick_origin();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return $urandom;
			2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_inv();
		case ($urandom_range(0, 5))
			0: return 32'h0001_0000;
			1: return '0;
			2: return 32'hFFFF_FFFF;
			3: return $urandom;
			default: return 32'($urandom_range(4096, 32'h0004_0000));
		endcase
	endfunction

	// world position within a couple of texels of the map
	function automatic logic [31:0] near_world(input logic signed [31:0] origin,
			input logic [31:0] inv, input int span);
		longint off;
		off = longint'($urandom_range(0, (span + 4) * 65536)) - 2 * 65536;
		if (inv != 0)
			off = (off * 65536) / longint'(inv);
		return 32'(longint'(origin) + off);
	endfunction

	task automatic push_random_request();
		request_t r;
		int       w, d, pick;
		w = eff_span(map_w_reg);
		d = eff_span(map_d_reg);
		pick = $urandom_range(0, 99);
		if (pick < 35)
			r.kind = KIND_WRITE;
		else if (pick < 55)
			r.kind = KIND_READ;
		else if (pick < 95)
			r.kind = KIND_SAMPLE;
		else
			r.kind = KIND_UNUSED;
		r.tx = 8'($urandom);
		r.tz = 8'($urandom);
		r.wh = 16'($urandom);
		r.wx = $urandom;
		r.wz = $urandom;
		if ($urandom_range(0, 3) != 0) begin
			r.tx = 8'($urandom_range(0, w - 1));
			r.tz = 8'($urandom_range(0, d - 1));
		end
		if ($urandom_range(0, 9) == 0)
			r.wh = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		if ($urandom_range(0, 9) < 7) begin
			r.wx = near_world(org_x_reg, inv_x_reg, w);
			r.wz = near_world(org_z_reg, inv_z_reg, d);
		end
		queue_request(r.kind, r.tx, r.tz, r.wh, r.wx, r.wz);
	endtask

	initial begin
		foreach (terrain[i])
			terrain[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: corners, sign extremes, half steps, clamps at both ends
		queue_request(KIND_WRITE, 8'd0, 8'd0, 16'h7FFF, '0, '0);
		queue_request(KIND_WRITE, 8'd1, 8'd0, 16'h8000, '0, '0);
		queue_request(KIND_WRITE, 8'd0, 8'd1, 16'h0100, '0, '0);
		queue_request(KIND_WRITE, 8'd1, 8'd1, 16'hFFFF, '0, '0);
		queue_request(KIND_WRITE, 8'd255, 8'd255, 16'h1234, '0, '0);
		queue_request(KIND_WRITE, 8'd254, 8'd255, 16'h5A5A, '0, '0);
		queue_request(KIND_WRITE, 8'd255, 8'd254, 16'hA5A5, '0, '0);
		queue_request(KIND_READ, 8'd0, 8'd0, '0, '0, '0);
		queue_request(KIND_READ, 8'd1, 8'd0, '0, '0, '0);
		queue_request(KIND_READ, 8'd255, 8'd255, '0, '0, '0);
		queue_request(KIND_READ, 8'd17, 8'd200, '0, '0, '0);
		queue_request(KIND_SAMPLE, '0, '0, '0, 32'h0000_0000, 32'h0000_0000);
		queue_request(KIND_SAMPLE, '0, '0, '0, 32'h0000_8000, 32'h0000_8000);
		queue_request(KIND_SAMPLE, '0, '0, '0, 32'h0000_FFFF, 32'h0001_0000);
		queue_request(KIND_SAMPLE, '0, '0, '0, 32'hFFFE_8000, 32'h0000_0000);
		queue_request(KIND_SAMPLE, '0, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_request(KIND_SAMPLE, '0, '0, '0, 32'h8000_0000, 32'h8000_0000);
		queue_request(KIND_SAMPLE, '0, '0, '0, 32'h00FE_8000, 32'h00FE_C000);
		queue_request(KIND_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		settle();

		// smallest map, full scale: out-of-range texels and clamped cells
		program_map(9'd3, 9'd3, 32'hFFFF_0000, '0, 32'h0002_0000, 32'h0000_8000, 16'hFFFF);
		queue_request(KIND_WRITE, 8'd2, 8'd2, 16'h7FFF, '0, '0);
		queue_request(KIND_WRITE, 8'd3, 8'd0, 16'h1234, '0, '0);
		queue_request(KIND_WRITE, 8'd0, 8'd3, 16'h1234, '0, '0);
		queue_request(KIND_WRITE, 8'd0, 8'd0, 16'h8000, '0, '0);
		queue_request(KIND_WRITE, 8'd1, 8'd1, 16'h7FFF, '0, '0);
		queue_request(KIND_WRITE, 8'd2, 8'd1, 16'h4000, '0, '0);
		queue_request(KIND_READ, 8'd3, 8'd1, '0, '0, '0);
		queue_request(KIND_READ, 8'd255, 8'd255, '0, '0, '0);
		queue_request(KIND_READ, 8'd2, 8'd2, '0, '0, '0);
		queue_request(KIND_READ, 8'd0, 8'd0, '0, '0, '0);
		queue_request(KIND_SAMPLE, '0, '0, '0, 32'h0000_0000, 32'h0000_0000);
		queue_request(KIND_SAMPLE, '0, '0, '0, 32'h0000_8000, 32'h0001_8000);
		queue_request(KIND_SAMPLE, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_request(KIND_SAMPLE, '0, '0, '0, 32'h0001_4000, 32'h0003_C000);
		queue_request(KIND_UNUSED, '0, '0, '0, '0, '0);
		settle();

		for (int p = 0; p < 10; p++) begin
			if (p == 2)
				program_map(9'd256, 9'd256, '0, '0, 32'h0001_0000, 32'h0001_0000, 16'h0100);
			else
				program_map(pick_size(), pick_size(), pick_origin(), pick_origin(),
					pick_inv(), pick_inv(), $urandom_range(0, 3) == 0 ? 16'hFFFF :
					($urandom_range(0, 3) == 0 ? 16'h0000 : 16'($urandom)));
			calm = (p == 4);
			repeat (140) push_random_request();
			settle();
		end
		calm = 1'b0;
		repeat (40) @(negedge clk);

		$display("Run: %0d items (%0d writes, %0d raw reads, %0d samples, %0d unused kind)",
			requests_taken, n_writes, n_reads, n_samples, n_unused);
		$display("Run: %0d out-of-range texels, %0d map layouts, %0d field errors",
			n_oor, n_layouts, error_count);
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
